@@ hw/rtl/prx_pkg.sv @@
// Shared types, constants and helpers for the printable run extractor.
`timescale 1ns / 1ps

package prx_pkg;

    // Widths and limits
    localparam int BYTE_W      = 8;
    localparam int MAX_RUN     = 63;
    localparam int CNT_W       = 6;
    localparam int OFFSET_BITS = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CNT_W-1:0] MIN_LENGTH_RESET = CNT_W'(4);

    // Printable range and tab
    localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMIT_START = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_OFFSET = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    // Configuration handed from the register file to the scanner
    typedef struct packed {
        logic [CNT_W-1:0] min_length;
        logic             emit_start;
    } t_cfg;

    // Run buffer access from the scanner
    typedef struct packed {
        logic              we;
        logic [CNT_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [CNT_W-1:0]  raddr;
    } t_ram_req;

    function automatic logic is_printable(input logic [BYTE_W-1:0] b);
        return ((b >= PRINT_LO) && (b <= PRINT_HI)) || (b == CHAR_TAB);
    endfunction

endpackage

@@ hw/rtl/printable_run_extractor_top.sv @@
// Top level of the printable run extractor: configuration registers, scanner and run buffer.
`timescale 1ns / 1ps

// Scans a byte stream for runs of printable ASCII (0x20..0x7E and tab) of at
// least min_length bytes (1..63, zero acts as one). The first min_length bytes
// of a run sit in a 63-entry run buffer RAM; when the run qualifies the block
// sends an optional start-offset record (register 1, emit_start) and then the
// held bytes, after which further printable bytes pass straight through. A
// non-printable byte or an end-of-stream mark closes a reported run with an end
// record, and end-of-stream also clears the 32-bit byte offset. An ordinary
// byte is taken whenever the output register is free. A byte that completes a
// run holds off input while the first held byte is read and the held bytes
// are replayed one per transfer, paced by the single read port of the run
// buffer and by the output register. Results leave through a one-deep output
// register; input is held off while a result waits there and the output side
// is not ready. Configuration must only be written while the block is idle.
module printable_run_extractor_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [prx_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [prx_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // byte stream in
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,   // [7:0] data_byte
    input  logic                               i_s_tuser,   // [0] end_of_stream
    // results out
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [39:0]                        o_m_tdata,   // [7:0] char_byte, [39:8] start_offset
    output logic [1:0]                         o_m_tuser,   // [1:0] kind
    output logic                               o_m_tlast
);

    prx_pkg::t_cfg                    r_cfg;
    prx_pkg::t_ram_req                ram;
    logic [prx_pkg::BYTE_W-1:0]       ram_rdata;
    prx_pkg::t_kind                   kind;
    logic [prx_pkg::BYTE_W-1:0]       char_byte;
    logic [prx_pkg::OFFSET_BITS-1:0]  start_offset;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_length <= prx_pkg::MIN_LENGTH_RESET;
            r_cfg.emit_start <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                prx_pkg::CFG_MIN_LENGTH: r_cfg.min_length <= i_cfg_wdata;
                prx_pkg::CFG_EMIT_START: r_cfg.emit_start <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    prx_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_data_byte    (i_s_tdata),
        .i_end_of_stream(i_s_tuser),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_kind         (kind),
        .o_char_byte    (char_byte),
        .o_start_offset (start_offset),
        .o_last         (o_m_tlast),
        .o_ram          (ram),
        .i_ram_rdata    (ram_rdata)
    );

    prx_run_ram #(
        .WIDTH(prx_pkg::BYTE_W),
        .DEPTH(prx_pkg::MAX_RUN),
        .AW   (prx_pkg::CNT_W)
    ) u_run_ram (
        .i_clk  (i_clk),
        .i_we   (ram.we),
        .i_waddr(ram.waddr),
        .i_wdata(ram.wdata),
        .i_re   (ram.re),
        .i_raddr(ram.raddr),
        .o_rdata(ram_rdata)
    );

    // Pack result fields
    assign o_m_tdata = {start_offset, char_byte};
    assign o_m_tuser = kind;

    // Character field is zero on offset and end records
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != prx_pkg::KIND_CHAR)) |-> (o_m_tdata[7:0] == 8'h00))
        else $error("char_byte nonzero on a non-character result");

    // Offset field is zero except on offset records
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != prx_pkg::KIND_OFFSET)) |-> (o_m_tdata[39:8] == '0))
        else $error("start_offset nonzero on a non-offset result");

    // An end record is always the last result of its input
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == prx_pkg::KIND_END)) |-> o_m_tlast)
        else $error("end record without tlast");

    // An offset record is always followed by held bytes
    a_off_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == prx_pkg::KIND_OFFSET)) |-> !o_m_tlast)
        else $error("offset record marked last");

endmodule

@@ hw/rtl/prx_run_ram.sv @@
// Simple dual-port RAM with registered read, holds the head of the current run.
`timescale 1ns / 1ps

module prx_run_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/prx_scan.sv @@
// Run scanner: classifies bytes, fills the run buffer, replays it and drives results.
`timescale 1ns / 1ps

module prx_scan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  prx_pkg::t_cfg                       i_cfg,
    // byte stream in
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [prx_pkg::BYTE_W-1:0]          i_data_byte,
    input  logic                                i_end_of_stream,
    // results out
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output prx_pkg::t_kind                      o_kind,
    output logic [prx_pkg::BYTE_W-1:0]          o_char_byte,
    output logic [prx_pkg::OFFSET_BITS-1:0]     o_start_offset,
    output logic                                o_last,
    // run buffer
    output prx_pkg::t_ram_req                   o_ram,
    input  logic [prx_pkg::BYTE_W-1:0]          i_ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_state                           r_state, n_state;
    logic [prx_pkg::CNT_W-1:0]        r_count, n_count;
    logic [prx_pkg::OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [prx_pkg::CNT_W-1:0]        r_idx, n_idx;
    logic [prx_pkg::CNT_W-1:0]        r_m, n_m;

    logic                             r_out_valid, n_out_valid;
    prx_pkg::t_kind                   r_out_kind, n_out_kind;
    logic [prx_pkg::BYTE_W-1:0]       r_out_char, n_out_char;
    logic [prx_pkg::OFFSET_BITS-1:0]  r_out_off, n_out_off;
    logic                             r_out_last, n_out_last;

    logic [prx_pkg::CNT_W-1:0]        eff_m;
    logic                             out_free;
    logic                             s_ready;
    logic                             accept;
    logic                             printable;
    logic                             reached;
    logic [prx_pkg::CNT_W-1:0]        cnt_inc;
    logic [prx_pkg::CNT_W-1:0]        idx_inc;
    logic                             replay_done;
    logic [prx_pkg::OFFSET_BITS-1:0]  run_start;
    prx_pkg::t_ram_req                ram;

    // Effective minimum length: zero acts as one
    assign eff_m = (i_cfg.min_length == '0) ? prx_pkg::CNT_W'(1) : i_cfg.min_length;

    // Output register is free when empty or being drained this cycle
    assign out_free  = !r_out_valid || i_m_tready;
    assign s_ready   = (r_state == S_IDLE) && out_free;
    assign accept    = i_s_tvalid && s_ready;
    assign printable = prx_pkg::is_printable(i_data_byte);
    assign reached   = (r_count >= eff_m);
    assign cnt_inc   = r_count + prx_pkg::CNT_W'(1);
    assign idx_inc   = r_idx + prx_pkg::CNT_W'(1);
    assign replay_done = (idx_inc == r_m);
    assign run_start = r_offset
                     - {{(prx_pkg::OFFSET_BITS-prx_pkg::CNT_W){1'b0}}, eff_m}
                     + prx_pkg::OFFSET_BITS'(1);

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_offset    = r_offset;
        n_idx       = r_idx;
        n_m         = r_m;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_char  = r_out_char;
        n_out_off   = r_out_off;
        n_out_last  = r_out_last;
        ram         = '0;

        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_end_of_stream) begin
                        if (reached) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = prx_pkg::KIND_END;
                            n_out_char  = '0;
                            n_out_off   = '0;
                            n_out_last  = 1'b1;
                        end
                        n_count  = '0;
                        n_offset = '0;
                    end else begin
                        n_offset = r_offset + prx_pkg::OFFSET_BITS'(1);
                        if (printable) begin
                            if (!reached) begin
                                // Hold the byte; replay once the run qualifies
                                ram.we    = 1'b1;
                                ram.waddr = r_count;
                                ram.wdata = i_data_byte;
                                n_count   = cnt_inc;
                                if (cnt_inc == eff_m) begin
                                    n_m     = eff_m;
                                    n_idx   = '0;
                                    n_state = S_READ;
                                    if (i_cfg.emit_start) begin
                                        n_out_valid = 1'b1;
                                        n_out_kind  = prx_pkg::KIND_OFFSET;
                                        n_out_char  = '0;
                                        n_out_off   = run_start;
                                        n_out_last  = 1'b0;
                                    end
                                end
                            end else begin
                                // Run already reported: pass through
                                n_out_valid = 1'b1;
                                n_out_kind  = prx_pkg::KIND_CHAR;
                                n_out_char  = i_data_byte;
                                n_out_off   = '0;
                                n_out_last  = 1'b1;
                            end
                        end else begin
                            if (reached) begin
                                n_out_valid = 1'b1;
                                n_out_kind  = prx_pkg::KIND_END;
                                n_out_char  = '0;
                                n_out_off   = '0;
                                n_out_last  = 1'b1;
                            end
                            n_count = '0;
                        end
                    end
                end
            end
            S_READ: begin
                // Fetch the first held byte
                ram.re    = 1'b1;
                ram.raddr = r_idx;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                // One held byte per transfer, prefetching the next one
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = prx_pkg::KIND_CHAR;
                    n_out_char  = i_ram_rdata;
                    n_out_off   = '0;
                    n_out_last  = replay_done;
                    if (replay_done) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx     = idx_inc;
                        ram.re    = 1'b1;
                        ram.raddr = idx_inc;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_offset    <= '0;
            r_idx       <= '0;
            r_m         <= prx_pkg::MIN_LENGTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_offset    <= n_offset;
            r_idx       <= n_idx;
            r_m         <= n_m;
            r_out_valid <= n_out_valid;
        end
        r_out_kind <= n_out_kind;
        r_out_char <= n_out_char;
        r_out_off  <= n_out_off;
        r_out_last <= n_out_last;
    end

    assign o_s_tready     = s_ready;
    assign o_m_tvalid     = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_char_byte    = r_out_char;
    assign o_start_offset = r_out_off;
    assign o_last         = r_out_last;
    assign o_ram          = ram;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the printable run extractor top level.
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_GOAL    = 410;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1_200_000;
    localparam int DIR_ROWS     = 29;

    // One output record of the scanner
    typedef struct {
        prx_pkg::t_kind kind;
        logic [7:0]     ch;
        logic [31:0]    offs;
        logic           last;
    } t_scan_rec;

    // Directed table: what a row does and how its result is known
    typedef enum {OP_BYTE, OP_EOS, OP_REG} t_row_op;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} t_chk;

    typedef struct {
        t_row_op                          op;
        logic [prx_pkg::CFG_ADDR_W-1:0]   addr;
        logic [7:0]                       val;
        t_chk                             chk;
        prx_pkg::t_kind                   kind;
        logic [7:0]                       ch;
    } t_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [prx_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [prx_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [7:0]                      i_s_tdata;   // [7:0] data_byte
    logic                            i_s_tuser;   // [0] end_of_stream
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [39:0]                     o_m_tdata;   // [7:0] char_byte, [39:8] start_offset
    logic [1:0]                      o_m_tuser;   // [1:0] kind
    logic                            o_m_tlast;

    // Scanner shadow state
    logic [7:0]                      run_held [prx_pkg::MAX_RUN];
    int                              run_len;
    logic [31:0]                     byte_pos;
    logic [prx_pkg::CNT_W-1:0]       sh_min_len;
    logic                            sh_emit_start;

    t_scan_rec              recs_due [$];
    t_scan_rec              recs_new [$];
    int                     items_sent;
    int                     err_cnt;
    int                     cyc_cnt;
    bit                     quiet;
    int                     stall_left;
    t_scan_rec              want;

    printable_run_extractor_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predict the records one stream item produces; leaves them in recs_new
    function automatic void predict_scan(input logic [7:0] b, input logic eos);
        int  m;
        bit  prt;
        m = (sh_min_len == 0) ? 1 : int'(sh_min_len);
        recs_new.delete();
        if (eos) begin
            if (run_len >= m) recs_new.push_back('{prx_pkg::KIND_END, 8'h00, 32'h0, 1'b0});
            run_len  = 0;
            byte_pos = 32'h0;
        end else begin
            prt = ((b >= prx_pkg::PRINT_LO) && (b <= prx_pkg::PRINT_HI)) ||
                  (b == prx_pkg::CHAR_TAB);
            if (prt) begin
                if (run_len < m) begin
                    run_held[run_len] = b;
                    run_len++;
                    if (run_len == m) begin
                        // run just qualified: start record, then replay
                        if (sh_emit_start)
                            recs_new.push_back('{prx_pkg::KIND_OFFSET, 8'h00,
                                                 byte_pos - 32'(m) + 32'd1, 1'b0});
                        for (int i = 0; i < m; i++)
                            recs_new.push_back('{prx_pkg::KIND_CHAR, run_held[i],
                                                 32'h0, 1'b0});
                    end
                end else begin
                    recs_new.push_back('{prx_pkg::KIND_CHAR, b, 32'h0, 1'b0});
                end
            end else begin
                if (run_len >= m)
                    recs_new.push_back('{prx_pkg::KIND_END, 8'h00, 32'h0, 1'b0});
                run_len = 0;
            end
            byte_pos = byte_pos + 32'd1;
        end
        if (recs_new.size() > 0) recs_new[recs_new.size()-1].last = 1'b1;
    endfunction

    // Present one stream item, wait for its transfer, then book its records
    task automatic push_item(input logic [7:0] b, input logic eos, input t_chk chk,
                             input prx_pkg::t_kind k, input logic [7:0] ch);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= eos;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
        predict_scan(b, eos);
        case (chk)
            CHK_MODEL: foreach (recs_new[i]) recs_due.push_back(recs_new[i]);
            CHK_ONE:   recs_due.push_back('{k, ch, 32'h0, 1'b1});
            default:   ;
        endcase
        // occasional gap on the input side
        if (!quiet && $urandom_range(0, 9) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Stop input and let the block empty out before touching registers
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (recs_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [prx_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [prx_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == prx_pkg::CFG_MIN_LENGTH) sh_min_len = val;
        else sh_emit_start = val[0];
        @(posedge i_clk);
    endtask

    // Output side: random stall bursts, none once the run goes quiet
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Compare each result transfer with the oldest booked record
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (recs_due.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result exp none act k=%0d c=%h o=%h l=%b",
                         $time, o_m_tuser, o_m_tdata[7:0], o_m_tdata[39:8], o_m_tlast);
            end else begin
                want = recs_due.pop_front();
                if (o_m_tuser !== want.kind || o_m_tdata[7:0] !== want.ch ||
                    o_m_tdata[39:8] !== want.offs || o_m_tlast !== want.last) begin
                    err_cnt++;
                    $display("%0t: mismatch exp k=%0d c=%h o=%h l=%b act k=%0d c=%h o=%h l=%b",
                             $time, want.kind, want.ch, want.offs, want.last,
                             o_m_tuser, o_m_tdata[7:0], o_m_tdata[39:8], o_m_tlast);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases
    initial begin
        t_row        dir_tab [DIR_ROWS];
        int          phase;
        int          m_sel;
        int          m_eff;
        int          runs;
        int          len;
        int          pick;
        bit          show_sel;
        logic [7:0]  b;

        dir_tab = '{
            '{OP_EOS,  prx_pkg::CFG_MIN_LENGTH, 8'h5A, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // close on empty stream
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h41, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h09, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // tab counts
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h20, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // low edge
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h7E, CHK_MODEL, prx_pkg::KIND_END,  8'h00}, // replay
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h7D, CHK_ONE,   prx_pkg::KIND_CHAR, 8'h7D}, // pass
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h7F, CHK_ONE,   prx_pkg::KIND_END,  8'h00}, // above
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h1F, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h00, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h08, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h0A, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_EOS,  prx_pkg::CFG_MIN_LENGTH, 8'hFF, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_REG,  prx_pkg::CFG_MIN_LENGTH, 8'h01, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_REG,  prx_pkg::CFG_EMIT_START, 8'h01, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'hFF, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h21, CHK_MODEL, prx_pkg::KIND_END,  8'h00}, // offset
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h7E, CHK_ONE,   prx_pkg::KIND_CHAR, 8'h7E},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h80, CHK_ONE,   prx_pkg::KIND_END,  8'h00},
            '{OP_REG,  prx_pkg::CFG_MIN_LENGTH, 8'h00, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // 0 as 1
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h09, CHK_MODEL, prx_pkg::KIND_END,  8'h00},
            '{OP_EOS,  prx_pkg::CFG_MIN_LENGTH, 8'h00, CHK_ONE,   prx_pkg::KIND_END,  8'h00}, // close
            '{OP_REG,  prx_pkg::CFG_MIN_LENGTH, 8'h03, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_REG,  prx_pkg::CFG_EMIT_START, 8'h00, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h78, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h79, CHK_NONE,  prx_pkg::KIND_END,  8'h00},
            '{OP_REG,  prx_pkg::CFG_MIN_LENGTH, 8'h02, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // shrink
            '{OP_BYTE, prx_pkg::CFG_MIN_LENGTH, 8'h7A, CHK_ONE,   prx_pkg::KIND_CHAR, 8'h7A}, // no replay
            '{OP_REG,  prx_pkg::CFG_MIN_LENGTH, 8'h05, CHK_NONE,  prx_pkg::KIND_END,  8'h00}, // grow
            '{OP_EOS,  prx_pkg::CFG_MIN_LENGTH, 8'h55, CHK_NONE,  prx_pkg::KIND_END,  8'h00}  // short
        };

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = prx_pkg::CFG_MIN_LENGTH;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 8'h00;
        i_s_tuser     = 1'b0;
        i_m_tready    = 1'b0;
        stall_left    = 0;
        quiet         = 1'b0;
        items_sent    = 0;
        err_cnt       = 0;
        cyc_cnt       = 0;
        run_len       = 0;
        byte_pos      = 32'h0;
        sh_min_len    = prx_pkg::MIN_LENGTH_RESET;
        sh_emit_start = 1'b0;
        foreach (run_held[i]) run_held[i] = 8'h00;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (dir_tab[r]) begin
            case (dir_tab[r].op)
                OP_REG: begin
                    wait_idle();
                    write_reg(dir_tab[r].addr, dir_tab[r].val[prx_pkg::CFG_DATA_W-1:0]);
                end
                OP_EOS:  push_item(dir_tab[r].val, 1'b1, dir_tab[r].chk,
                                   dir_tab[r].kind, dir_tab[r].ch);
                default: push_item(dir_tab[r].val, 1'b0, dir_tab[r].chk,
                                   dir_tab[r].kind, dir_tab[r].ch);
            endcase
        end

        // random phases, each with its own register setting
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase)
                0: begin m_sel = prx_pkg::MAX_RUN; show_sel = 1'b1; end
                1: begin m_sel = 1;                show_sel = 1'b0; end
                2: begin m_sel = 0;                show_sel = 1'b1; end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)      m_sel = $urandom_range(1, 6);
                    else if (pick < 9) m_sel = $urandom_range(0, 20);
                    else               m_sel = $urandom_range(21, prx_pkg::MAX_RUN);
                    show_sel = $urandom_range(0, 1);
                end
            endcase
            wait_idle();
            write_reg(prx_pkg::CFG_MIN_LENGTH, prx_pkg::CFG_DATA_W'(m_sel));
            write_reg(prx_pkg::CFG_EMIT_START, prx_pkg::CFG_DATA_W'(show_sel));
            m_eff = (m_sel == 0) ? 1 : m_sel;
            runs  = (m_eff > 20) ? 1 : $urandom_range(3, 8);

            repeat (runs) begin
                if ($urandom_range(0, 9) < 7) begin
                    // a printable run of random length near the threshold
                    len = (m_eff > 20) ? m_eff + $urandom_range(0, 3)
                                       : $urandom_range(0, m_eff + 6);
                    repeat (len) begin
                        b = ($urandom_range(0, 15) == 0) ? prx_pkg::CHAR_TAB
                                                         : 8'($urandom_range(8'h7E, 8'h20));
                        push_item(b, 1'b0, CHK_MODEL, prx_pkg::KIND_END, 8'h00);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        do b = 8'($urandom_range(0, 255));
                        while (!((b < 8'h20 && b != 8'h09) || b > 8'h7E));
                        push_item(b, 1'b0, CHK_MODEL, prx_pkg::KIND_END, 8'h00);
                    end else if (pick < 9) begin
                        push_item(8'($urandom_range(0, 255)), 1'b1, CHK_MODEL,
                                  prx_pkg::KIND_END, 8'h00);
                    end
                end else begin
                    // noise: any byte, now and then an end of stream
                    repeat ($urandom_range(1, 4))
                        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0,
                                  CHK_MODEL, prx_pkg::KIND_END, 8'h00);
                end
                if (items_sent >= ITEM_GOAL - QUIET_ITEMS) quiet = 1'b1;
            end
            phase++;
        end

        wait_idle();
        if (err_cnt == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
